@@ sv/aes_keyless_round_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the keyless AES round core
// Shared property wrappers used by the round core RTL.
// ----------------------------------------------------------------------------
`ifndef AES_KEYLESS_ROUND_CORE_DEFINES_SVH
`define AES_KEYLESS_ROUND_CORE_DEFINES_SVH

// Implication checked on every clock edge outside reset
`define AKR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication whose consequent is checked in the cycle after the antecedent
`define AKR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ sv/akr_pkg.sv @@
// ----------------------------------------------------------------------------
// Keyless AES round package
// Byte helpers in GF(2^8) and the substitution tables.
// ----------------------------------------------------------------------------
package akr_pkg;

  localparam int unsigned WordW = 64;
  localparam logic [7:0]  GfReduce = 8'h1b;

  typedef enum logic {
    REQ_FWD = 1'b0,
    REQ_INV = 1'b1
  } req_type_t;

  typedef logic [7:0] byte_t;
  typedef byte_t [15:0] block_t;

  function automatic byte_t gf_dbl(byte_t v);
    return {v[6:0], 1'b0} ^ (v[7] ? GfReduce : 8'h00);
  endfunction

  function automatic byte_t gf_mul(byte_t a, byte_t b);
    byte_t acc;
    byte_t x;
    acc = '0;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = gf_dbl(x);
    end
    return acc;
  endfunction

  function automatic byte_t sbox_fwd(byte_t x);
    byte_t t [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
    return t[x];
  endfunction

  function automatic byte_t sbox_inv(byte_t x);
    byte_t t [256] = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
    return t[x];
  endfunction

endpackage

@@ sv/akr_if.sv @@
// ----------------------------------------------------------------------------
// Keyless AES round channels
// Valid/ready interfaces for request and result items.
// ----------------------------------------------------------------------------
interface akr_req_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [akr_pkg::WordW-1:0]     state_hi;
  logic [akr_pkg::WordW-1:0]     state_lo;

  modport source (output valid, req_type, state_hi, state_lo, input ready);
  modport sink   (input valid, req_type, state_hi, state_lo, output ready);
endinterface

interface akr_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [akr_pkg::WordW-1:0]     result_hi;
  logic [akr_pkg::WordW-1:0]     result_lo;

  modport source (output valid, result_hi, result_lo, input ready);
  modport sink   (input valid, result_hi, result_lo, output ready);
endinterface

@@ sv/aes_keyless_round_core.sv @@
// ----------------------------------------------------------------------------
// Keyless AES round core
// One AES round (or inverse round) without AddRoundKey per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : request channel, valid/ready, carries req_type and the 128-bit
//           state as state_hi/state_lo (byte 0 in the top bits of state_hi,
//           loaded column by column).
//   out_* : result channel, valid/ready, same byte order.
//   Each item passes an input register, then the S-box, row shift and
//   column mix into the output register, whose valid flag drives
//   out_valid.
//   Throughput is one item per cycle; both stages advance whenever the
//   output register is empty or being taken, so a stalled receiver stops
//   the pipe and in_ready falls once both registers hold items and the
//   receiver is not ready.
//   The path between the registers is one table lookup and one column mix.
//   Reset clears both valid flags, so no item is held over; the data registers are not reset.
// ----------------------------------------------------------------------------
`include "aes_keyless_round_core_defines.svh"

module aes_keyless_round_core (
  input  logic           clk,
  input  logic           rst_n,
  akr_req_if.sink        in_ch,
  akr_rsp_if.source      out_ch
);

  logic                  s1_vld_r;
  logic                  s1_inv_r;
  akr_pkg::block_t       s1_blk_r;
  logic                  s2_vld_r;
  akr_pkg::block_t       s2_blk_r;
  logic                  s2_adv;
  logic                  s1_adv;
  akr_pkg::block_t       in_blk;
  akr_pkg::block_t       sub_blk;
  akr_pkg::block_t       mix_blk;

  assign s2_adv = !s2_vld_r || out_ch.ready;
  assign s1_adv = !s1_vld_r || s2_adv;
  assign in_ch.ready = s1_adv;

  // byte k at index k: byte 0 is the top byte of state_hi
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      in_blk[k]     = in_ch.state_hi[8*(7-k) +: 8];
      in_blk[k + 8] = in_ch.state_lo[8*(7-k) +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_adv) begin
      s1_vld_r <= in_ch.valid;
    end
    if (s1_adv && in_ch.valid) begin
      s1_blk_r <= in_blk;
      s1_inv_r <= in_ch.req_type;
    end
  end

  // substitute and shift rows; byte (r, c) is index 4c + r
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        if (s1_inv_r == akr_pkg::REQ_INV) begin
          sub_blk[4*c + r] = akr_pkg::sbox_inv(s1_blk_r[4*((c + 4 - r) % 4) + r]);
        end else begin
          sub_blk[4*c + r] = akr_pkg::sbox_fwd(s1_blk_r[4*((c + r) % 4) + r]);
        end
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        if (s1_inv_r == akr_pkg::REQ_INV) begin
          mix_blk[4*c + r] =
            akr_pkg::gf_mul(sub_blk[4*c + r],           8'h0e) ^
            akr_pkg::gf_mul(sub_blk[4*c + (r + 1) % 4], 8'h0b) ^
            akr_pkg::gf_mul(sub_blk[4*c + (r + 2) % 4], 8'h0d) ^
            akr_pkg::gf_mul(sub_blk[4*c + (r + 3) % 4], 8'h09);
        end else begin
          mix_blk[4*c + r] =
            akr_pkg::gf_dbl(sub_blk[4*c + r]) ^
            akr_pkg::gf_dbl(sub_blk[4*c + (r + 1) % 4]) ^ sub_blk[4*c + (r + 1) % 4] ^
            sub_blk[4*c + (r + 2) % 4] ^ sub_blk[4*c + (r + 3) % 4];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (s2_adv) begin
      s2_vld_r <= s1_vld_r;
    end
    if (s2_adv && s1_vld_r) begin
      s2_blk_r <= mix_blk;
    end
  end

  assign out_ch.valid = s2_vld_r;
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      out_ch.result_hi[8*(7-k) +: 8] = s2_blk_r[k];
      out_ch.result_lo[8*(7-k) +: 8] = s2_blk_r[k + 8];
    end
  end

  // a stalled result holds its place
  `AKR_ASSERT_NXT(a_hold, clk, rst_n, s2_vld_r && !out_ch.ready, s2_vld_r)
  // input stalls only when both stages are full
  `AKR_ASSERT_IMP(a_rdy, clk, rst_n, !in_ch.ready, s1_vld_r && s2_vld_r)
  // an accepted item occupies the first stage next cycle
  `AKR_ASSERT_NXT(a_take, clk, rst_n, in_ch.valid && in_ch.ready, s1_vld_r)

endmodule
